@@ sv/pdh_pkg.sv @@
// types, codes and constants shared by the pair distance histogram block
`default_nettype none

package pdh_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   localparam logic [2:0] CSR_BOX_LEN_X   = 3'd0;
   localparam logic [2:0] CSR_BOX_LEN_Y   = 3'd1;
   localparam logic [2:0] CSR_BOX_LEN_Z   = 3'd2;
   localparam logic [2:0] CSR_TILT_XY     = 3'd3;
   localparam logic [2:0] CSR_TILT_XZ     = 3'd4;
   localparam logic [2:0] CSR_TILT_YZ     = 3'd5;
   localparam logic [2:0] CSR_BIN_WIDTH   = 3'd6;
   localparam logic [2:0] CSR_BINS_IN_USE = 3'd7;

   localparam logic [7:0]  KIND_COUNTED = 8'd1;
   localparam logic [31:0] PAIR_WEIGHT  = 32'd2;
   localparam logic [31:0] BIN_MAX      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [30:0]        box_len_x;
      logic [30:0]        box_len_y;
      logic [30:0]        box_len_z;
      logic signed [31:0] tilt_xy;
      logic signed [31:0] tilt_xz;
      logic signed [31:0] tilt_yz;
      logic [30:0]        bin_width;
      logic [10:0]        bins_in_use;
   } config_type;

   typedef struct packed {
      logic done;
      logic hit;
   } pair_status_type;

   typedef enum logic [3:0] {
      CS_SWEEP,
      CS_IDLE,
      CS_ATOM_RD,
      CS_ATOM_CHK,
      CS_PAIR,
      CS_HIST_UPD,
      CS_STORE,
      CS_READ,
      CS_REPLY
   } ctrl_state_type;

   typedef enum logic [3:0] {
      PS_IDLE,
      PS_MUL,
      PS_SUM,
      PS_SQ,
      PS_SQSUM,
      PS_TOTAL,
      PS_ROOT,
      PS_CHECK,
      PS_DIV
   } pair_state_type;

endpackage

`default_nettype wire

@@ sv/pdh_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module pdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/pdh_pair.sv @@
// pair unit: minimum-image distance of one atom pair and its histogram bin
`default_nettype none

module pdh_pair #(
   parameter int MAX_BINS = 1024,
   localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  pdh_pkg::config_type         cfg,
   input  wire logic [10:0]            bin_limit,
   input  wire logic [31:0]            new_x,
   input  wire logic [31:0]            new_y,
   input  wire logic [31:0]            new_z,
   input  wire logic [31:0]            old_x,
   input  wire logic [31:0]            old_y,
   input  wire logic [31:0]            old_z,
   output pdh_pkg::pair_status_type    status,
   output logic [BIN_W-1:0]            bin
);

   import pdh_pkg::*;

   localparam int DVW = (31 + BIN_W > 33) ? 31 + BIN_W : 33;

   pair_state_type state_ff, state_in;
   logic           done_set, hit_set, done_ff, hit_ff;

   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic [41:0]        nbw_ff;
   logic signed [56:0] pxx_ff, pxy_ff, pxz_ff, pyy_ff, pyz_ff, pzz_ff;
   logic [55:0]        mx_ff, my_ff, mz_ff;
   logic [55:0]        hh_ff [3];
   logic [55:0]        hl_ff [3];
   logic [55:0]        ll_ff [3];
   logic [111:0]       sq_ff [3];
   logic [65:0]        q_ff;
   logic [32:0]        root_ff;
   logic [33:0]        rem_ff;
   logic [5:0]         cnt_ff;
   logic [32:0]        div_rem_ff;
   logic [DVW-1:0]     divisor_ff;
   logic [BIN_W-1:0]   quot_ff;

   logic signed [57:0] rx, ry, rz;
   logic [113:0]       dist_sq;
   logic [35:0]        rem_sh, trial;
   logic               root_ge, div_ge;

   function automatic logic signed [24:0] wrap_diff(input logic [31:0] a, input logic [31:0] b);
      logic [24:0] d;
      d = a[24:0] - b[24:0];
      if (d[23:0] > 24'h80_0000 || (d[23:0] == 24'h80_0000 && d[24])) begin
         return {1'b1, d[23:0]};
      end
      return {1'b0, d[23:0]};
   endfunction

   function automatic logic [55:0] mag(input logic signed [57:0] v);
      logic [57:0] a;
      a = v[57] ? 58'(-v) : 58'(v);
      return a[55:0];
   endfunction

   assign rx = 58'(pxx_ff) + 58'(pxy_ff) + 58'(pxz_ff);
   assign ry = 58'(pyy_ff) + 58'(pyz_ff);
   assign rz = 58'(pzz_ff);
   assign dist_sq = 114'(sq_ff[0]) + 114'(sq_ff[1]) + 114'(sq_ff[2]);
   assign rem_sh = {rem_ff, q_ff[65:64]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign root_ge = rem_sh >= trial;
   assign div_ge = DVW'(div_rem_ff) >= divisor_ff;

   assign status = '{done: done_ff, hit: hit_ff};
   assign bin = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_set;
      end
      if (done_set) begin
         hit_ff <= hit_set;
      end
   end

   always_comb begin
      state_in = state_ff;
      done_set = 1'b0;
      hit_set = 1'b0;
      unique case (state_ff)
         PS_IDLE: begin
            if (start) begin
               state_in = PS_MUL;
            end
         end
         PS_MUL:   state_in = PS_SUM;
         PS_SUM:   state_in = PS_SQ;
         PS_SQ:    state_in = PS_SQSUM;
         PS_SQSUM: state_in = PS_TOTAL;
         PS_TOTAL: state_in = PS_ROOT;
         PS_ROOT: begin
            if (cnt_ff == '0) begin
               state_in = PS_CHECK;
            end
         end
         PS_CHECK: begin
            if (42'(root_ff) < nbw_ff) begin
               state_in = PS_DIV;
            end else begin
               state_in = PS_IDLE;
               done_set = 1'b1;
            end
         end
         PS_DIV: begin
            if (cnt_ff == '0) begin
               state_in = PS_IDLE;
               done_set = 1'b1;
               hit_set = 1'b1;
            end
         end
         default: state_in = PS_IDLE;
      endcase
   end

   // datapath, one step per state
   always_ff @(posedge clock) begin
      case (state_ff)
         PS_IDLE: begin
            dx_ff <= wrap_diff(old_x, new_x);
            dy_ff <= wrap_diff(old_y, new_y);
            dz_ff <= wrap_diff(old_z, new_z);
            nbw_ff <= bin_limit * cfg.bin_width;
         end
         PS_MUL: begin
            pxx_ff <= $signed({1'b0, cfg.box_len_x}) * dx_ff;
            pxy_ff <= $signed(cfg.tilt_xy) * dy_ff;
            pxz_ff <= $signed(cfg.tilt_xz) * dz_ff;
            pyy_ff <= $signed({1'b0, cfg.box_len_y}) * dy_ff;
            pyz_ff <= $signed(cfg.tilt_yz) * dz_ff;
            pzz_ff <= $signed({1'b0, cfg.box_len_z}) * dz_ff;
         end
         PS_SUM: begin
            mx_ff <= mag(rx);
            my_ff <= mag(ry);
            mz_ff <= mag(rz);
         end
         PS_SQ: begin
            hh_ff[0] <= mx_ff[55:28] * mx_ff[55:28];
            hl_ff[0] <= mx_ff[55:28] * mx_ff[27:0];
            ll_ff[0] <= mx_ff[27:0] * mx_ff[27:0];
            hh_ff[1] <= my_ff[55:28] * my_ff[55:28];
            hl_ff[1] <= my_ff[55:28] * my_ff[27:0];
            ll_ff[1] <= my_ff[27:0] * my_ff[27:0];
            hh_ff[2] <= mz_ff[55:28] * mz_ff[55:28];
            hl_ff[2] <= mz_ff[55:28] * mz_ff[27:0];
            ll_ff[2] <= mz_ff[27:0] * mz_ff[27:0];
         end
         PS_SQSUM: begin
            for (int i = 0; i < 3; i++) begin
               sq_ff[i] <= (112'(hh_ff[i]) << 56) + (112'(hl_ff[i]) << 29) + 112'(ll_ff[i]);
            end
         end
         PS_TOTAL: begin
            q_ff <= dist_sq[113:48];
            root_ff <= '0;
            rem_ff <= '0;
            cnt_ff <= 6'd32;
         end
         PS_ROOT: begin
            q_ff <= {q_ff[63:0], 2'b00};
            cnt_ff <= cnt_ff - 6'd1;
            if (root_ge) begin
               rem_ff <= 34'(rem_sh - trial);
               root_ff <= {root_ff[31:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[33:0];
               root_ff <= {root_ff[31:0], 1'b0};
            end
         end
         PS_CHECK: begin
            div_rem_ff <= root_ff;
            divisor_ff <= DVW'(cfg.bin_width) << (BIN_W - 1);
            quot_ff <= '0;
            cnt_ff <= 6'(BIN_W - 1);
         end
         PS_DIV: begin
            if (div_ge) begin
               div_rem_ff <= 33'(DVW'(div_rem_ff) - divisor_ff);
            end
            quot_ff <= BIN_W'({quot_ff, div_ge});
            divisor_ff <= divisor_ff >> 1;
            cnt_ff <= cnt_ff - 6'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/pair_distance_histogram.sv @@
// pair distance histogram of type-1 atoms in a periodic triclinic box
//
// requests arrive on req_* (valid/ready); each gives exactly one response on
// rsp_* (valid/ready). csr_* writes the box, tilt and binning registers and
// is always ready; write it only while the block is idle.
// clear empties the atom store and zeroes the histogram, then gives its response.
// add of a type-1 atom walks every stored atom: one of the same molecule is
// skipped, any other goes through the bit-serial square root in the pair unit,
// and one whose distance hits the histogram also through the bin divider and
// an update of its bin; the atom is then written to the store if it has room.
// read fetches the selected bin from the histogram memory and replies with it.
// requests are handled one at a time; a new request is taken while the last
// response still waits on a stalled receiver, and finishes only once that
// response has been taken.
// after reset the histogram memory is swept to zero while req_ready stays low.
`default_nettype none

module pair_distance_histogram #(
   parameter int MAX_ATOMS = 4096,
   parameter int MAX_BINS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_molecule_id,
   input  wire logic [7:0]  req_atom_kind,
   input  wire logic [31:0] req_scaled_x,
   input  wire logic [31:0] req_scaled_y,
   input  wire logic [31:0] req_scaled_z,
   input  wire logic [9:0]  req_bin_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_bin_value,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   import pdh_pkg::*;

   localparam int AAW = $clog2(MAX_ATOMS);
   localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int ATOM_DW = 112;

   ctrl_state_type   state_ff, state_in;
   config_type       cfg_ff;
   logic [15:0]      mol_ff;
   logic [31:0]      sx_ff, sy_ff, sz_ff;
   logic [AAW:0]     total_ff;
   logic [AAW-1:0]   idx_ff;
   logic [BIN_W-1:0] sweep_ff;
   logic             pending_ff;
   logic [31:0]      value_ff;
   status_type       status_ff;
   logic             rsp_valid_ff;
   logic [31:0]      rsp_value_ff;
   logic [1:0]       rsp_status_ff;

   logic             accept, in_range, last, advance, rsp_load, pair_start;
   logic [10:0]      nb;
   logic             atom_rd, atom_wr;
   logic [ATOM_DW-1:0] atom_rd_data;
   logic             hist_rd, hist_wr;
   logic [BIN_W-1:0] hist_rd_addr, hist_wr_addr, pair_bin;
   logic [31:0]      hist_rd_data, hist_wr_data;
   pair_status_type  pair_status;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == CS_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_bin_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   assign nb = (17'(cfg_ff.bins_in_use) < 17'(MAX_BINS)) ? cfg_ff.bins_in_use : 11'(MAX_BINS);
   assign in_range = 11'(req_bin_select) < nb;
   assign last = ((AAW + 1)'(idx_ff) + (AAW + 1)'(1)) == total_ff;

   pdh_ram #(.WIDTH(ATOM_DW), .DEPTH(MAX_ATOMS)) u_atom_ram (
      .clock   (clock),
      .wr_en   (atom_wr),
      .wr_addr (total_ff[AAW-1:0]),
      .wr_data ({mol_ff, sx_ff, sy_ff, sz_ff}),
      .rd_en   (atom_rd),
      .rd_addr (idx_ff),
      .rd_data (atom_rd_data)
   );

   pdh_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   pdh_pair #(.MAX_BINS(MAX_BINS)) u_pair (
      .clock     (clock),
      .reset     (reset),
      .start     (pair_start),
      .cfg       (cfg_ff),
      .bin_limit (nb),
      .new_x     (sx_ff),
      .new_y     (sy_ff),
      .new_z     (sz_ff),
      .old_x     (atom_rd_data[95:64]),
      .old_y     (atom_rd_data[63:32]),
      .old_z     (atom_rd_data[31:0]),
      .status    (pair_status),
      .bin       (pair_bin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      atom_rd = 1'b0;
      atom_wr = 1'b0;
      hist_rd = 1'b0;
      hist_rd_addr = pair_bin;
      hist_wr = 1'b0;
      hist_wr_addr = pair_bin;
      hist_wr_data = (hist_rd_data > BIN_MAX - PAIR_WEIGHT) ? BIN_MAX
                                                            : hist_rd_data + PAIR_WEIGHT;
      pair_start = 1'b0;
      advance = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         CS_SWEEP: begin
            hist_wr = 1'b1;
            hist_wr_addr = sweep_ff;
            hist_wr_data = '0;
            if (sweep_ff == BIN_W'(MAX_BINS - 1)) begin
               state_in = pending_ff ? CS_REPLY : CS_IDLE;
            end
         end
         CS_IDLE: begin
            if (accept) begin
               unique case (command_type'(req_command))
                  CMD_CLEAR: state_in = CS_SWEEP;
                  CMD_ADD: begin
                     if (req_atom_kind != KIND_COUNTED) begin
                        state_in = CS_REPLY;
                     end else if (total_ff == '0) begin
                        state_in = CS_STORE;
                     end else begin
                        state_in = CS_ATOM_RD;
                     end
                  end
                  CMD_READ: begin
                     if (in_range) begin
                        hist_rd = 1'b1;
                        hist_rd_addr = BIN_W'(req_bin_select);
                        state_in = CS_READ;
                     end else begin
                        state_in = CS_REPLY;
                     end
                  end
                  default: state_in = CS_REPLY;
               endcase
            end
         end
         CS_ATOM_RD: begin
            atom_rd = 1'b1;
            state_in = CS_ATOM_CHK;
         end
         CS_ATOM_CHK: begin
            if (atom_rd_data[111:96] != mol_ff) begin
               pair_start = 1'b1;
               state_in = CS_PAIR;
            end else begin
               advance = 1'b1;
            end
         end
         CS_PAIR: begin
            if (pair_status.done) begin
               if (pair_status.hit) begin
                  hist_rd = 1'b1;
                  state_in = CS_HIST_UPD;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         CS_HIST_UPD: begin
            hist_wr = 1'b1;
            advance = 1'b1;
         end
         CS_STORE: begin
            atom_wr = (total_ff < (AAW + 1)'(MAX_ATOMS));
            state_in = CS_REPLY;
         end
         CS_READ: state_in = CS_REPLY;
         CS_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
      if (advance) begin
         state_in = last ? CS_STORE : CS_ATOM_RD;
      end
   end

   // control counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         sweep_ff <= '0;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff <= '{box_len_x: 31'd65536, box_len_y: 31'd65536, box_len_z: 31'd65536,
                     tilt_xy: 32'sd0, tilt_xz: 32'sd0, tilt_yz: 32'sd0,
                     bin_width: 31'd6554, bins_in_use: 11'd1024};
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BOX_LEN_X:   cfg_ff.box_len_x <= csr_data[30:0];
               CSR_BOX_LEN_Y:   cfg_ff.box_len_y <= csr_data[30:0];
               CSR_BOX_LEN_Z:   cfg_ff.box_len_z <= csr_data[30:0];
               CSR_TILT_XY:     cfg_ff.tilt_xy <= csr_data;
               CSR_TILT_XZ:     cfg_ff.tilt_xz <= csr_data;
               CSR_TILT_YZ:     cfg_ff.tilt_yz <= csr_data;
               CSR_BIN_WIDTH:   cfg_ff.bin_width <= csr_data[30:0];
               CSR_BINS_IN_USE: cfg_ff.bins_in_use <= csr_data[10:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            pending_ff <= 1'b1;
            if (command_type'(req_command) == CMD_CLEAR) begin
               total_ff <= '0;
            end
         end
         if (state_ff == CS_SWEEP) begin
            sweep_ff <= sweep_ff + BIN_W'(1);
         end else begin
            sweep_ff <= '0;
         end
         if (atom_wr) begin
            total_ff <= total_ff + (AAW + 1)'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request payload and result
   always_ff @(posedge clock) begin
      if (accept) begin
         mol_ff <= req_molecule_id;
         sx_ff <= req_scaled_x;
         sy_ff <= req_scaled_y;
         sz_ff <= req_scaled_z;
         idx_ff <= '0;
         value_ff <= '0;
         status_ff <= (command_type'(req_command) == CMD_READ && !in_range) ? STATUS_RANGE
                                                                            : STATUS_OK;
      end else if (advance) begin
         idx_ff <= idx_ff + AAW'(1);
      end
      if (state_ff == CS_STORE && !atom_wr) begin
         status_ff <= STATUS_FULL;
      end
      if (state_ff == CS_READ) begin
         value_ff <= hist_rd_data;
      end
      if (rsp_load) begin
         rsp_value_ff <= value_ff;
         rsp_status_ff <= status_ff;
      end
   end

endmodule

`default_nettype wire

@@ sv/pdh_checker.sv @@
// port-level checks for the pair distance histogram and their binding
`default_nettype none

module pdh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_bin_value,
   input wire logic [1:0]  rsp_status
);

   import pdh_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_value) && $stable(rsp_status))
      else $error("stalled response changed");

   // only a good read carries a count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_bin_value == 32'd0)
      else $error("error response with nonzero count");

   // histogram sweep after reset blocks requests
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during reset sweep");

   // one request at a time
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after accept");

endmodule

bind pair_distance_histogram pdh_checker u_pdh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_bin_value (rsp_bin_value),
   .rsp_status    (rsp_status)
);

`default_nettype wire

@@ sim/pair_distance_histogram_tb.sv @@
// testbench for the pair distance histogram block: directed and random requests against a predictor
`default_nettype none

module pair_distance_histogram_tb;
   import pdh_pkg::*;

   localparam int ATOM_CAP = 64;
   localparam int BIN_CAP = 1024;

   typedef struct {
      command_type cmd;
      logic [15:0] mol;
      logic [7:0]  kind;
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] sz;
      logic [9:0]  sel;
      logic        pinned;
      logic [31:0] pin_value;
      status_type  pin_status;
   } request_type;

   typedef struct {
      logic [31:0] bin_value;
      status_type  status;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = CMD_NONE;
   logic [15:0] req_molecule_id = '0;
   logic [7:0] req_atom_kind = '0;
   logic [31:0] req_scaled_x = '0;
   logic [31:0] req_scaled_y = '0;
   logic [31:0] req_scaled_z = '0;
   logic [9:0] req_bin_select = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_bin_value;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = CSR_BOX_LEN_X;
   logic [31:0] csr_data = '0;

   logic pin_flag = 1'b0;
   logic [31:0] pin_value = '0;
   status_type pin_status = STATUS_OK;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int adds_seen = 0;
   int reads_seen = 0;
   int full_seen = 0;
   int range_seen = 0;

   logic [30:0] box_x, box_y, box_z, bin_w;
   logic signed [31:0] tilt_xy, tilt_xz, tilt_yz;
   logic [10:0] bins_used;
   logic [15:0] atom_mol [ATOM_CAP];
   logic signed [31:0] atom_x [ATOM_CAP];
   logic signed [31:0] atom_y [ATOM_CAP];
   logic signed [31:0] atom_z [ATOM_CAP];
   int atom_count;
   logic [31:0] hist_model [BIN_CAP];
   reply_type pending_replies [$];

   pair_distance_histogram #(
      .MAX_ATOMS(ATOM_CAP),
      .MAX_BINS(BIN_CAP)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_molecule_id(req_molecule_id),
      .req_atom_kind(req_atom_kind),
      .req_scaled_x(req_scaled_x),
      .req_scaled_y(req_scaled_y),
      .req_scaled_z(req_scaled_z),
      .req_bin_select(req_bin_select),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_bin_value(rsp_bin_value),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #100_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic longint wrap_q24(longint d);
      logic [63:0] u;
      logic [23:0] frac;
      u = d + (64'sd1 <<< 40);
      frac = u[23:0];
      if (frac > 24'h800000 || (frac == 24'h800000 && u[24]))
         return longint'({40'b0, frac}) - 64'sh1000000;
      return longint'({40'b0, frac});
   endfunction

   function automatic logic [127:0] square_mag(longint v);
      logic [127:0] m;
      m = {64'b0, (v < 0) ? -v : v};
      return m * m;
   endfunction

   function automatic int distance_bin(logic [127:0] dsq);
      logic [127:0] q, kw;
      int nb, lo, hi, mid;
      nb = (bins_used < BIN_CAP) ? bins_used : BIN_CAP;
      if (nb == 0 || bin_w == 0)
         return -1;
      q = dsq >> 48;
      kw = nb * {97'b0, bin_w};
      if (kw * kw <= q)
         return -1;
      lo = 0;
      hi = nb - 1;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         kw = mid * {97'b0, bin_w};
         if (kw * kw <= q)
            lo = mid;
         else
            hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic void count_pair(int j, request_type r);
      longint dx, dy, dz, rx, ry, rz;
      int b;
      dx = wrap_q24(longint'(atom_x[j]) - longint'(signed'(r.sx)));
      dy = wrap_q24(longint'(atom_y[j]) - longint'(signed'(r.sy)));
      dz = wrap_q24(longint'(atom_z[j]) - longint'(signed'(r.sz)));
      rx = longint'({33'b0, box_x}) * dx + longint'(tilt_xy) * dy + longint'(tilt_xz) * dz;
      ry = longint'({33'b0, box_y}) * dy + longint'(tilt_yz) * dz;
      rz = longint'({33'b0, box_z}) * dz;
      b = distance_bin(square_mag(rx) + square_mag(ry) + square_mag(rz));
      if (b >= 0)
         hist_model[b] = (hist_model[b] > BIN_MAX - PAIR_WEIGHT) ? BIN_MAX
                                                                 : hist_model[b] + PAIR_WEIGHT;
   endfunction

   function automatic reply_type histogram_step(request_type r);
      reply_type y;
      int nb;
      y.bin_value = '0;
      y.status = STATUS_OK;
      case (r.cmd)
         CMD_CLEAR: begin
            atom_count = 0;
            foreach (hist_model[i]) hist_model[i] = '0;
         end
         CMD_ADD: begin
            if (r.kind == KIND_COUNTED) begin
               adds_seen++;
               for (int j = 0; j < atom_count; j++)
                  if (atom_mol[j] != r.mol)
                     count_pair(j, r);
               if (atom_count < ATOM_CAP) begin
                  atom_mol[atom_count] = r.mol;
                  atom_x[atom_count] = r.sx;
                  atom_y[atom_count] = r.sy;
                  atom_z[atom_count] = r.sz;
                  atom_count++;
               end else begin
                  y.status = STATUS_FULL;
                  full_seen++;
               end
            end
         end
         CMD_READ: begin
            reads_seen++;
            nb = (bins_used < BIN_CAP) ? bins_used : BIN_CAP;
            if (r.sel < nb) begin
               y.bin_value = hist_model[r.sel];
            end else begin
               y.status = STATUS_RANGE;
               range_seen++;
            end
         end
         default: begin
         end
      endcase
      return y;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      request_type r;
      reply_type y, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("unexpected response", rsp_bin_value, '0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_bin_value !== want.bin_value)
                  report_mismatch("bin_value", rsp_bin_value, want.bin_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", {30'b0, rsp_status}, {30'b0, want.status});
            end
         end
         if (req_valid && req_ready) begin
            r.cmd = command_type'(req_command);
            r.mol = req_molecule_id;
            r.kind = req_atom_kind;
            r.sx = req_scaled_x;
            r.sy = req_scaled_y;
            r.sz = req_scaled_z;
            r.sel = req_bin_select;
            y = histogram_step(r);
            if (pin_flag) begin
               y.bin_value = pin_value;
               y.status = pin_status;
            end
            pending_replies.push_back(y);
         end
      end
   end

   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = r.cmd;
      req_molecule_id = r.mol;
      req_atom_kind = r.kind;
      req_scaled_x = r.sx;
      req_scaled_y = r.sy;
      req_scaled_z = r.sz;
      req_bin_select = r.sel;
      pin_flag = r.pinned;
      pin_value = r.pin_value;
      pin_status = r.pin_status;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BOX_LEN_X: box_x = value[30:0];
         CSR_BOX_LEN_Y: box_y = value[30:0];
         CSR_BOX_LEN_Z: box_z = value[30:0];
         CSR_TILT_XY: tilt_xy = value;
         CSR_TILT_XZ: tilt_xz = value;
         CSR_TILT_YZ: tilt_yz = value;
         CSR_BIN_WIDTH: bin_w = value[30:0];
         CSR_BINS_IN_USE: bins_used = value[10:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain_replies();
      req_valid = 1'b0;
      while (pending_replies.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic apply_setting(int n);
      logic [31:0] v [8];
      case (n)
         0: v = '{32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd6554, 32'd1000};
         1: v = '{32'h7FFF_FFFF, 32'd1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'hFFFF_0000, 32'h7FFF_FFFF, 32'd2047};
         2: v = '{32'h0005_0000, 32'h0003_0000, 32'h0004_0000, 32'h0000_8000,
                  32'hFFFF_C000, 32'd0, 32'd0, 32'd0};
         default: v = '{32'h000A_0000, 32'h0008_0000, 32'h0006_0000, 32'h0002_0000,
                        32'hFFFF_0000, 32'h0001_8000, 32'h0001_0000, 32'd16};
      endcase
      for (int i = 0; i < 8; i++)
         write_reg(i[2:0], v[i]);
   endtask

   function automatic request_type make_row(command_type c, logic [15:0] mol, logic [7:0] kind,
                                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [9:0] sel, logic pinned, status_type st);
      request_type r;
      r = '{c, mol, kind, x, y, z, sel, pinned, 32'd0, st};
      return r;
   endfunction

   function automatic logic [31:0] pick_coord();
      if ($urandom_range(99) < 60)
         return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      return $urandom;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int pick;
      pick = $urandom_range(99);
      r.cmd = (pick < 4) ? CMD_CLEAR : (pick < 70) ? CMD_ADD : (pick < 97) ? CMD_READ : CMD_NONE;
      r.mol = ($urandom_range(99) < 80) ? 16'($urandom_range(7)) : 16'($urandom);
      r.kind = ($urandom_range(99) < 85) ? KIND_COUNTED : 8'($urandom);
      r.sx = pick_coord();
      r.sy = pick_coord();
      r.sz = pick_coord();
      r.sel = ($urandom_range(99) < 75) ? 10'($urandom_range(15)) : 10'($urandom);
      r.pinned = 1'b0;
      r.pin_value = '0;
      r.pin_status = STATUS_OK;
      return r;
   endfunction

   initial begin
      request_type directed [$];
      box_x = 31'd65536;
      box_y = 31'd65536;
      box_z = 31'd65536;
      tilt_xy = '0;
      tilt_xz = '0;
      tilt_yz = '0;
      bin_w = 31'd6554;
      bins_used = 11'd1024;
      atom_count = 0;
      foreach (hist_model[i]) hist_model[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset state under default registers
      send_request(make_row(CMD_READ, 0, 0, 0, 0, 0, 10'd0, 1, STATUS_OK));
      send_request(make_row(CMD_READ, 0, 0, 0, 0, 0, 10'd1023, 1, STATUS_OK));
      drain_replies();
      apply_setting(0);

      directed.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, 10'd999, 1, STATUS_OK));
      directed.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, 10'd1000, 1, STATUS_RANGE));
      directed.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, 10'd1023, 1, STATUS_RANGE));
      directed.push_back(make_row(CMD_NONE, 16'hFFFF, 8'hFF, '1, '1, '1, '1, 1, STATUS_OK));
      directed.push_back(make_row(CMD_ADD, 0, 8'd0, 32'h7FFF_FFFF, 0, 0, 0, 1, STATUS_OK));
      directed.push_back(make_row(CMD_ADD, 0, 8'hFF, 0, 0, 0, 0, 1, STATUS_OK));
      directed.push_back(make_row(CMD_ADD, 0, KIND_COUNTED, 0, 0, 0, 0, 1, STATUS_OK));
      // half-box tie, rounds to even
      directed.push_back(make_row(CMD_ADD, 1, KIND_COUNTED, 32'h0080_0000, 0, 0, 0, 1, STATUS_OK));
      directed.push_back(make_row(CMD_ADD, 1, KIND_COUNTED, 32'h0180_0000, 32'h0040_0000, 0, 0,
                                  1, STATUS_OK));
      directed.push_back(make_row(CMD_ADD, 0, KIND_COUNTED, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'hFF80_0000, 0, 1, STATUS_OK));
      directed.push_back(make_row(CMD_ADD, 16'hFFFF, KIND_COUNTED, '1, 32'd1, 32'h0040_0000, 0,
                                  1, STATUS_OK));
      directed.push_back(make_row(CMD_ADD, 16'h8000, KIND_COUNTED, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h0123_4567, 0, 1, STATUS_OK));
      for (int b = 0; b < 8; b++)
         directed.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, b[9:0], 0, STATUS_OK));
      directed.push_back(make_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1, STATUS_OK));
      directed.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, 10'd5, 1, STATUS_OK));
      foreach (directed[i])
         send_request(directed[i]);

      for (int phase = 0; phase < 4; phase++) begin
         drain_replies();
         apply_setting(phase == 0 ? 3 : phase);
         send_idle_pct = (phase == 1) ? 70 : (phase == 3) ? 16 : 0;
         recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 16 : 0;
         for (int n = 0; n < 26; n++)
            send_request(random_request());
         send_idle_pct = 0;
         recv_stall_pct = 0;
         for (int n = 0; n < 4; n++)
            send_request(random_request());
      end

      drain_replies();
      $display("covered %0d counted adds (%0d with a full store), %0d reads (%0d out of range)",
               adds_seen, full_seen, reads_seen, range_seen);
      $display("over four register settings and idle patterns on both channels");
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
